FILE: rtl/cuwd_pkg.sv
// cuwd_pkg: shared types and codes for the compact unwind word decoder
// holds the slot and descriptor types passed from front end through queue to back end
// no dependencies
`default_nettype none

package cuwd_pkg;

    localparam int MAX_SLOTS  = 18;
    localparam int SLOT_IDX_W = 5;

    localparam logic [2:0] KIND_UNKNOWN   = 3'd0;
    localparam logic [2:0] KIND_NONE      = 3'd1;
    localparam logic [2:0] KIND_FRAME     = 3'd2;
    localparam logic [2:0] KIND_IMMEDIATE = 3'd3;
    localparam logic [2:0] KIND_INDIRECT  = 3'd4;
    localparam logic [2:0] KIND_DWARF     = 3'd5;

    localparam logic [1:0] CLS_EMPTY = 2'd0;
    localparam logic [1:0] CLS_GPR   = 2'd1;
    localparam logic [1:0] CLS_FPR   = 2'd2;

    typedef struct packed {
        logic [1:0] cls;
        logic [4:0] rg;
    } slot_t;

    typedef struct packed {
        logic [2:0]                 kind;
        logic [15:0]                stack_size;
        logic                       has_stack_size;
        logic [23:0]                dwarf_offset;
        logic [10:0]                frame_offset;
        logic [28:0]                gpr_mask;
        logic [15:0]                fpr_mask;
        logic                       word_valid;
        logic [SLOT_IDX_W-1:0]      len;
        slot_t [MAX_SLOTS-1:0]      slots;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/cuwd_front.sv
// cuwd_front: accepts a word, classifies it and builds the slot list step by step
// uses cuwd_pkg; hands a finished entry_t to the queue
`default_nettype none

module cuwd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [1:0]      arch,
    input  wire logic [31:0]     word,
    output logic                 busy,
    output cuwd_pkg::entry_t     entry,
    output logic                 entry_valid,
    input  wire logic            entry_ready
);
    import cuwd_pkg::*;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_RUN  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    localparam logic [1:0] JOB_NONE   = 2'd0;
    localparam logic [1:0] JOB_FRAME  = 2'd1;
    localparam logic [1:0] JOB_LEHMER = 2'd2;
    localparam logic [1:0] JOB_PAIRS  = 2'd3;

    localparam logic [1:0] ARCH_X64   = 2'd0;
    localparam logic [1:0] ARCH_X86   = 2'd1;
    localparam logic [1:0] ARCH_ARM64 = 2'd2;

    localparam logic [3:0] MODE_ZERO = 4'd0;
    localparam logic [3:0] MODE_ONE  = 4'd1;
    localparam logic [3:0] MODE_TWO  = 4'd2;
    localparam logic [3:0] MODE_THREE = 4'd3;
    localparam logic [3:0] MODE_FOUR = 4'd4;

    function automatic logic [4:0] reg_map(input logic is64, input logic [2:0] n);
        logic [4:0] r;
        begin
            r = 5'd0;
            case (n)
                3'd1: r = 5'd3;
                3'd2: r = is64 ? 5'd12 : 5'd1;
                3'd3: r = is64 ? 5'd13 : 5'd2;
                3'd4: r = is64 ? 5'd14 : 5'd7;
                3'd5: r = is64 ? 5'd15 : 5'd6;
                3'd6: r = 5'd5;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [6:0] lehmer_div(input logic [2:0] cnt, input logic [2:0] i);
        logic [6:0] d;
        begin
            d = 7'd0;
            case (cnt)
                3'd1: d = (i == 3'd0) ? 7'd1 : 7'd0;
                3'd2:
                begin
                    case (i)
                        3'd0: d = 7'd5;
                        3'd1: d = 7'd1;
                        default: d = 7'd0;
                    endcase
                end
                3'd3:
                begin
                    case (i)
                        3'd0: d = 7'd20;
                        3'd1: d = 7'd4;
                        3'd2: d = 7'd1;
                        default: d = 7'd0;
                    endcase
                end
                3'd4:
                begin
                    case (i)
                        3'd0: d = 7'd60;
                        3'd1: d = 7'd12;
                        3'd2: d = 7'd3;
                        3'd3: d = 7'd1;
                        default: d = 7'd0;
                    endcase
                end
                3'd5, 3'd6:
                begin
                    case (i)
                        3'd0: d = 7'd120;
                        3'd1: d = 7'd24;
                        3'd2: d = 7'd6;
                        3'd3: d = 7'd2;
                        3'd4: d = 7'd1;
                        default: d = 7'd0;
                    endcase
                end
                default: d = 7'd0;
            endcase
            return d;
        end
    endfunction

    function automatic logic [4:0] pair_first(input logic [3:0] i);
        logic [4:0] r;
        begin
            case (i)
                4'd0: r = 5'd19;
                4'd1: r = 5'd21;
                4'd2: r = 5'd23;
                4'd3: r = 5'd25;
                4'd4: r = 5'd27;
                4'd5: r = 5'd8;
                4'd6: r = 5'd10;
                4'd7: r = 5'd12;
                4'd8: r = 5'd14;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    logic [1:0]                 state_reg, state_next;
    logic [31:0]                word_reg, word_next;
    logic [1:0]                 arch_reg, arch_next;
    logic [1:0]                 job_reg, job_next;
    logic [3:0]                 nsteps_reg, nsteps_next;
    logic [3:0]                 step_reg, step_next;
    logic [9:0]                 perm_reg, perm_next;
    logic [5:0]                 used_reg, used_next;
    logic [SLOT_IDX_W-1:0]      fill_reg, fill_next;
    logic [SLOT_IDX_W-1:0]      len_reg, len_next;
    logic [28:0]                gpr_reg, gpr_next;
    logic [15:0]                fpr_reg, fpr_next;
    logic                       ok_reg, ok_next;
    slot_t [MAX_SLOTS-1:0]      slots_reg, slots_next;

    logic [3:0]  in_mode;
    logic [3:0]  mode;
    logic [2:0]  nib;
    logic [6:0]  div;
    logic [2:0]  digit;
    logic [2:0]  rank;
    logic [2:0]  pick;
    logic        found;
    logic        pbit;
    logic [4:0]  first;
    logic [4:0]  mapped;

    assign in_mode = word[27:24];
    assign mode    = word_reg[27:24];
    assign busy    = (state_reg != FS_IDLE);

    // summary fields and the finished entry
    always_comb
    begin
        entry = '0;
        entry.slots = slots_reg;
        if (arch_reg == ARCH_X64 || arch_reg == ARCH_X86)
        begin
            if (mode == MODE_ONE)
            begin
                entry.kind = KIND_FRAME;
                entry.frame_offset = (arch_reg == ARCH_X64) ? {word_reg[23:16], 3'b000}
                                                            : {1'b0, word_reg[23:16], 2'b00};
            end
            else if (mode == MODE_TWO)
            begin
                entry.kind = KIND_IMMEDIATE;
                entry.stack_size = (arch_reg == ARCH_X64) ? {5'd0, word_reg[23:16], 3'b000}
                                                          : {6'd0, word_reg[23:16], 2'b00};
                entry.has_stack_size = 1'b1;
            end
            else if (mode == MODE_THREE)
            begin
                entry.kind = KIND_INDIRECT;
            end
            else if (mode == MODE_FOUR)
            begin
                entry.kind = KIND_DWARF;
                entry.dwarf_offset = word_reg[23:0];
            end
        end
        else if (arch_reg == ARCH_ARM64)
        begin
            if (mode == MODE_FOUR)
            begin
                entry.kind = KIND_FRAME;
            end
            else if (mode == MODE_TWO)
            begin
                entry.kind = KIND_IMMEDIATE;
                entry.stack_size = {word_reg[23:12], 4'b0000};
                entry.has_stack_size = 1'b1;
            end
            else if (mode == MODE_THREE)
            begin
                entry.kind = KIND_DWARF;
                entry.dwarf_offset = word_reg[23:0];
            end
        end
        else
        begin
            if (mode == MODE_ONE || mode == MODE_TWO)
            begin
                entry.kind = KIND_FRAME;
            end
            else if (mode == MODE_FOUR)
            begin
                entry.kind = KIND_DWARF;
                entry.dwarf_offset = word_reg[23:0];
            end
        end
        if (entry.kind == KIND_UNKNOWN && mode == MODE_ZERO)
        begin
            entry.kind = KIND_NONE;
        end
        entry.word_valid = ok_reg;
        entry.gpr_mask   = ok_reg ? gpr_reg : 29'd0;
        entry.fpr_mask   = ok_reg ? fpr_reg : 16'd0;
        entry.len        = ok_reg ? len_reg : '0;
    end

    assign entry_valid = (state_reg == FS_PUSH);

    // per-step helpers
    always_comb
    begin
        nib = 3'(word_reg >> (5'(step_reg) * 5'd3));
        div = lehmer_div(word_reg[12:10], step_reg[2:0]);
        digit = 3'd0;
        if (div != 7'd0)
        begin
            for (int j = 1; j <= 7; j++)
            begin
                if (perm_reg >= 10'(div) * 10'(j))
                begin
                    digit = 3'(j);
                end
            end
        end
        rank  = 3'd0;
        pick  = 3'd0;
        found = 1'b0;
        for (int r = 1; r <= 6; r++)
        begin
            if (!found && !used_reg[r-1])
            begin
                if (rank == digit)
                begin
                    pick  = 3'(r);
                    found = 1'b1;
                end
                else
                begin
                    rank = rank + 3'd1;
                end
            end
        end
        pbit  = (step_reg < 4'd5) ? word_reg[5'(step_reg)] : word_reg[5'(step_reg) + 5'd3];
        first = pair_first(step_reg);
        mapped = reg_map(arch_reg == ARCH_X64, (job_reg == JOB_FRAME) ? nib : pick);
    end

    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        arch_next   = arch_reg;
        job_next    = job_reg;
        nsteps_next = nsteps_reg;
        step_next   = step_reg;
        perm_next   = perm_reg;
        used_next   = used_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        gpr_next    = gpr_reg;
        fpr_next    = fpr_reg;
        ok_next     = ok_reg;
        slots_next  = slots_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    state_next  = FS_RUN;
                    word_next   = word;
                    arch_next   = arch;
                    step_next   = 4'd0;
                    perm_next   = word[9:0];
                    used_next   = 6'd0;
                    fill_next   = '0;
                    len_next    = '0;
                    gpr_next    = 29'd0;
                    fpr_next    = 16'd0;
                    ok_next     = 1'b1;
                    job_next    = JOB_NONE;
                    nsteps_next = 4'd0;
                    if (arch == ARCH_X64 || arch == ARCH_X86)
                    begin
                        if (in_mode == MODE_ONE)
                        begin
                            job_next    = JOB_FRAME;
                            nsteps_next = 4'd5;
                        end
                        else if (in_mode == MODE_TWO || in_mode == MODE_THREE)
                        begin
                            job_next    = JOB_LEHMER;
                            nsteps_next = {1'b0, word[12:10]};
                            // permutation count of seven is inconsistent
                            if (word[12:10] == 3'd7)
                            begin
                                ok_next = 1'b0;
                            end
                        end
                    end
                    else if (arch == ARCH_ARM64)
                    begin
                        if (in_mode == MODE_FOUR || in_mode == MODE_TWO)
                        begin
                            job_next    = JOB_PAIRS;
                            nsteps_next = 4'd9;
                        end
                    end
                end
            end
            FS_RUN:
            begin
                if (step_reg == nsteps_reg || !ok_reg)
                begin
                    state_next = FS_PUSH;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                    case (job_reg)
                        JOB_FRAME:
                        begin
                            if (nib == 3'd0)
                            begin
                                slots_next[fill_reg] = '{cls: CLS_EMPTY, rg: 5'd0};
                                fill_next = fill_reg + 1'b1;
                            end
                            else if (nib >= 3'd6)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                slots_next[fill_reg] = '{cls: CLS_GPR, rg: mapped};
                                fill_next = fill_reg + 1'b1;
                                // trailing empty slots fall outside len
                                len_next  = fill_reg + 1'b1;
                                gpr_next  = gpr_reg | (29'd1 << mapped);
                            end
                        end
                        JOB_LEHMER:
                        begin
                            if (!found)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                slots_next[fill_reg] = '{cls: CLS_GPR, rg: mapped};
                                fill_next = fill_reg + 1'b1;
                                len_next  = fill_reg + 1'b1;
                                gpr_next  = gpr_reg | (29'd1 << mapped);
                                used_next = used_reg | (6'd1 << (pick - 3'd1));
                                perm_next = perm_reg - 10'(div) * 10'(digit);
                            end
                        end
                        JOB_PAIRS:
                        begin
                            if (pbit)
                            begin
                                if (step_reg < 4'd5)
                                begin
                                    slots_next[fill_reg] = '{cls: CLS_GPR, rg: first};
                                    slots_next[fill_reg + 1'b1] =
                                        '{cls: CLS_GPR, rg: first + 5'd1};
                                    gpr_next = gpr_reg | (29'd1 << first)
                                               | (29'd1 << (first + 5'd1));
                                end
                                else
                                begin
                                    slots_next[fill_reg] = '{cls: CLS_FPR, rg: first};
                                    slots_next[fill_reg + 1'b1] =
                                        '{cls: CLS_FPR, rg: first + 5'd1};
                                    fpr_next = fpr_reg | (16'd1 << first[3:0])
                                               | (16'd1 << (first[3:0] + 4'd1));
                                end
                                fill_next = fill_reg + 5'd2;
                                len_next  = fill_reg + 5'd2;
                            end
                        end
                        default:
                        begin
                            state_next = FS_PUSH;
                        end
                    endcase
                end
            end
            FS_PUSH:
            begin
                if (entry_ready)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        arch_reg   <= arch_next;
        job_reg    <= job_next;
        nsteps_reg <= nsteps_next;
        step_reg   <= step_next;
        perm_reg   <= perm_next;
        used_reg   <= used_next;
        fill_reg   <= fill_next;
        len_reg    <= len_next;
        gpr_reg    <= gpr_next;
        fpr_reg    <= fpr_next;
        ok_reg     <= ok_next;
        slots_reg  <= slots_next;
    end

endmodule

`default_nettype wire

FILE: rtl/cuwd_queue.sv
// cuwd_queue: short fifo of decoded entries between front and back end
// uses cuwd_pkg for entry_t
`default_nettype none

module cuwd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  cuwd_pkg::entry_t  in_entry,
    input  wire logic         in_valid,
    output logic              in_ready,
    output cuwd_pkg::entry_t  out_entry,
    output logic              out_valid,
    input  wire logic         out_pop
);
    import cuwd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_entry = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cuwd_back.sv
// cuwd_back: walks the slot list of the head entry and emits one result per cycle
// uses cuwd_pkg for entry_t
`default_nettype none

module cuwd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  cuwd_pkg::entry_t   entry,
    input  wire logic          entry_valid,
    output logic               entry_pop,
    output logic               result_strobe,
    output logic [2:0]         kind,
    output logic [15:0]        stack_size,
    output logic               has_stack_size,
    output logic [23:0]        dwarf_offset,
    output logic [10:0]        frame_offset,
    output logic [28:0]        gpr_mask,
    output logic [15:0]        fpr_mask,
    output logic               word_valid,
    output logic               slot_present,
    output logic [1:0]         slot_class,
    output logic [4:0]         slot_register,
    output logic               last_slot
);
    import cuwd_pkg::*;

    logic [SLOT_IDX_W-1:0] k_reg, k_next;
    logic [SLOT_IDX_W-1:0] n_results;
    slot_t                 cur;

    // an empty list still gives one result
    assign n_results = (entry.len == '0) ? SLOT_IDX_W'(1) : entry.len;
    assign cur       = entry.slots[k_reg];

    assign result_strobe  = entry_valid;
    assign kind           = entry.kind;
    assign stack_size     = entry.stack_size;
    assign has_stack_size = entry.has_stack_size;
    assign dwarf_offset   = entry.dwarf_offset;
    assign frame_offset   = entry.frame_offset;
    assign gpr_mask       = entry.gpr_mask;
    assign fpr_mask       = entry.fpr_mask;
    assign word_valid     = entry.word_valid;
    assign slot_present   = (entry.len != '0);
    assign slot_class     = slot_present ? cur.cls : CLS_EMPTY;
    assign slot_register  = slot_present ? cur.rg : 5'd0;
    assign last_slot      = (k_reg + 1'b1 == n_results);
    assign entry_pop      = entry_valid && last_slot;

    always_comb
    begin
        k_next = k_reg;
        if (entry_pop)
        begin
            k_next = '0;
        end
        else if (entry_valid)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/compact_unwind_word_decoder_unit.sv
// compact_unwind_word_decoder_unit: top level of the compact unwind word decoder
// uses cuwd_pkg, cuwd_front, cuwd_queue and cuwd_back
//
// usage:
//   cfg_we/cfg_wdata write the architecture register (0 x86-64, 1 x86, 2 arm64,
//   3 arm32) while the block is idle; reset sets it to x86-64.
//   an item is taken on a clock edge with start high and busy low.
//   the front end holds busy from acceptance until the decoded entry enters the
//   queue: it loads the word, takes one step per frame slot (5), per
//   permutation digit (0..6) or per arm64 register pair bit (9), and then
//   hands the entry off to the queue.
//   the back end emits one result per cycle with result_strobe high, one per
//   saved slot (at least one, at most 18), last_slot on the final one; the
//   first result appears once the entry reaches the head of the queue.
//   a queue of QUEUE_DEPTH entries lets the front end decode the next item while
//   earlier results drain; a decoded entry waits, busy high, on a full queue.
//   the receiver cannot stall: each result stands for exactly one cycle.
//   reset empties the queue and returns the front end to idle.
`default_nettype none

module compact_unwind_word_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_wdata,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [31:0]   encoding_word,
    output logic               result_strobe,
    output logic [2:0]         kind,
    output logic [15:0]        stack_size,
    output logic               has_stack_size,
    output logic [23:0]        dwarf_offset,
    output logic [10:0]        frame_offset,
    output logic [28:0]        gpr_mask,
    output logic [15:0]        fpr_mask,
    output logic               word_valid,
    output logic               slot_present,
    output logic [1:0]         slot_class,
    output logic [4:0]         slot_register,
    output logic               last_slot
);
    import cuwd_pkg::*;

    logic [1:0] arch_reg, arch_next;
    entry_t     front_entry;
    logic       front_valid;
    logic       front_ready;
    entry_t     head_entry;
    logic       head_valid;
    logic       head_pop;

    assign arch_next = cfg_we ? cfg_wdata : arch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_reg <= 2'd0;
        end
        else
        begin
            arch_reg <= arch_next;
        end
    end

    cuwd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .arch        (arch_reg),
        .word        (encoding_word),
        .busy        (busy),
        .entry       (front_entry),
        .entry_valid (front_valid),
        .entry_ready (front_ready)
    );

    cuwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (front_entry),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_entry (head_entry),
        .out_valid (head_valid),
        .out_pop   (head_pop)
    );

    cuwd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .entry          (head_entry),
        .entry_valid    (head_valid),
        .entry_pop      (head_pop),
        .result_strobe  (result_strobe),
        .kind           (kind),
        .stack_size     (stack_size),
        .has_stack_size (has_stack_size),
        .dwarf_offset   (dwarf_offset),
        .frame_offset   (frame_offset),
        .gpr_mask       (gpr_mask),
        .fpr_mask       (fpr_mask),
        .word_valid     (word_valid),
        .slot_present   (slot_present),
        .slot_class     (slot_class),
        .slot_register  (slot_register),
        .last_slot      (last_slot)
    );

    // an inconsistent word never carries slots or masks
    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !word_valid |-> !slot_present && gpr_mask == 29'd0
                                         && fpr_mask == 16'd0)
        else $error("inconsistent word carries slots");

    // an empty list is a single result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !slot_present |-> last_slot)
        else $error("empty list result not marked last");

    // trailing empty slots are trimmed
    a_trimmed: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && slot_present && last_slot |-> slot_class != CLS_EMPTY)
        else $error("final slot is empty");

    // summary fields stay fixed within one item's results
    a_summary_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_slot |=> result_strobe && $stable(kind)
                                        && $stable(gpr_mask) && $stable(fpr_mask))
        else $error("summary changed inside an item");

endmodule

`default_nettype wire
